// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while reset is released
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/u2e_pkg.sv =====
// Types, character codes and helpers of the UTF-8 to escape converter.
// No dependencies; used by the front, queue and back modules.
`timescale 1ns / 1ps

package u2e_pkg;

  // What one accepted byte asks the back end to emit
  typedef enum logic [1:0] {
    JOB_CHAR = 2'd0,
    JOB_ESC  = 2'd1,
    JOB_PAIR = 2'd2
  } job_kind_e;

  // One request to the back end; a plain character sits in hi[6:0]
  typedef struct packed {
    job_kind_e   kind;
    logic [15:0] hi;
    logic [15:0] lo;
  } job_t;

  localparam int unsigned AccW   = 36;
  localparam int unsigned RemW   = 3;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned EscLen = 6;

  localparam logic [6:0] ChrBslash = 7'h5C;
  localparam logic [6:0] ChrLowU   = 7'h75;

  localparam logic [25:0] SuppBase = 26'h10000;
  localparam logic [15:0] HiSurr   = 16'hD800;
  localparam logic [5:0]  LoSurrHi = 6'b110111;

  // Last character index for each kind of request
  localparam logic [IdxW-1:0] LastChar = 4'd0;
  localparam logic [IdxW-1:0] LastEsc  = 4'd5;
  localparam logic [IdxW-1:0] LastPair = 4'd11;

  // Uppercase hex digit of a nibble
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage

// ===== design/u2e_front.sv =====
// Front end: decodes UTF-8 bytes, gathers code points and forms requests.
// Depends on u2e_pkg.
`timescale 1ns / 1ps

module u2e_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        in_byte_i,
  input  logic              restart_i,
  output logic              job_valid_o,
  output u2e_pkg::job_t     job_o
);

  logic [u2e_pkg::RemW-1:0] rem_q, rem_d, rem_eff, rem_dec;
  logic [u2e_pkg::AccW-1:0] acc_q, acc_d, acc_eff, acc_shift;
  logic [25:0]              supp_off;
  logic                     is_small;
  logic [u2e_pkg::RemW-1:0] lead_n;
  logic [5:0]               lead_bits;

  // Restart discards an unfinished sequence before the byte is used
  assign rem_eff   = restart_i ? '0 : rem_q;
  assign acc_eff   = restart_i ? '0 : acc_q;
  assign acc_shift = {acc_eff[u2e_pkg::AccW-7:0], in_byte_i[5:0]};
  assign rem_dec   = rem_eff - 3'd1;

  // Split a finished code point into escape values
  assign is_small = (acc_shift[u2e_pkg::AccW-1:16] == '0);
  assign supp_off = acc_shift[25:0] - u2e_pkg::SuppBase;

  // Count the length ones of a lead byte and keep its payload bits
  always_comb begin
    if (!in_byte_i[5]) begin
      lead_n    = 3'd1;
      lead_bits = {1'b0, in_byte_i[4:0]};
    end else if (!in_byte_i[4]) begin
      lead_n    = 3'd2;
      lead_bits = {2'b00, in_byte_i[3:0]};
    end else if (!in_byte_i[3]) begin
      lead_n    = 3'd3;
      lead_bits = {3'b000, in_byte_i[2:0]};
    end else if (!in_byte_i[2]) begin
      lead_n    = 3'd4;
      lead_bits = {4'b0000, in_byte_i[1:0]};
    end else if (!in_byte_i[1]) begin
      lead_n    = 3'd5;
      lead_bits = {5'b00000, in_byte_i[0]};
    end else begin
      lead_n    = 3'd6;
      lead_bits = 6'd0;
    end
  end

  // Classify the byte and advance the sequence state
  always_comb begin
    rem_d       = rem_q;
    acc_d       = acc_q;
    job_valid_o = 1'b0;
    job_o.kind  = u2e_pkg::JOB_CHAR;
    job_o.hi    = {9'd0, in_byte_i[6:0]};
    job_o.lo    = 16'd0;
    if (accept_i) begin
      if (rem_eff != '0) begin
        rem_d = rem_dec;
        acc_d = acc_shift;
        if (rem_dec == '0) begin
          acc_d       = '0;
          job_valid_o = 1'b1;
          if (is_small) begin
            job_o.kind = u2e_pkg::JOB_ESC;
            job_o.hi   = acc_shift[15:0];
          end else begin
            job_o.kind = u2e_pkg::JOB_PAIR;
            job_o.hi   = supp_off[25:10] + u2e_pkg::HiSurr;
            job_o.lo   = {u2e_pkg::LoSurrHi, supp_off[9:0]};
          end
        end
      end else if (!in_byte_i[7]) begin
        rem_d       = '0;
        acc_d       = '0;
        job_valid_o = 1'b1;
      end else if (!in_byte_i[6]) begin
        // stray continuation byte: drop
        rem_d = '0;
        acc_d = '0;
      end else begin
        rem_d = lead_n;
        acc_d = {{(u2e_pkg::AccW-6){1'b0}}, lead_bits};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      acc_q <= '0;
    end else begin
      rem_q <= rem_d;
      acc_q <= acc_d;
    end
  end

endmodule

// ===== design/u2e_fifo.sv =====
// Short request queue between the front and back ends.
// Depends on u2e_pkg for the request type.
`timescale 1ns / 1ps

module u2e_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  u2e_pkg::job_t wr_data_i,
  input  logic          rd_i,
  output u2e_pkg::job_t rd_data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  u2e_pkg::job_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Store requests
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/u2e_back.sv =====
// Back end: spells each request as ASCII characters, one per cycle unless
// the output stalls. Depends on u2e_pkg.
`timescale 1ns / 1ps

module u2e_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  u2e_pkg::job_t job_i,
  output logic          job_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [6:0]    out_char_o,
  output logic          last_o
);

  logic [u2e_pkg::IdxW-1:0] idx_q, idx_d, last_idx;
  logic [2:0]               pos;
  logic [15:0]              esc_val;
  logic [3:0]               nib;
  logic [6:0]               chr;
  logic                     is_last, advance;
  logic                     out_valid_q, out_valid_d;
  logic [6:0]               out_char_q;
  logic                     last_q;

  // Final character index of the current request
  always_comb begin
    case (job_i.kind)
      u2e_pkg::JOB_CHAR: last_idx = u2e_pkg::LastChar;
      u2e_pkg::JOB_ESC:  last_idx = u2e_pkg::LastEsc;
      u2e_pkg::JOB_PAIR: last_idx = u2e_pkg::LastPair;
      default:           last_idx = u2e_pkg::LastChar;
    endcase
  end

  assign is_last = (idx_q == last_idx);

  // Pick the character at the current index
  always_comb begin
    if (idx_q >= u2e_pkg::IdxW'(u2e_pkg::EscLen)) begin
      pos     = 3'(idx_q - u2e_pkg::IdxW'(u2e_pkg::EscLen));
      esc_val = job_i.lo;
    end else begin
      pos     = idx_q[2:0];
      esc_val = job_i.hi;
    end
    case (pos)
      3'd2:    nib = esc_val[15:12];
      3'd3:    nib = esc_val[11:8];
      3'd4:    nib = esc_val[7:4];
      default: nib = esc_val[3:0];
    endcase
    case (pos)
      3'd0:    chr = u2e_pkg::ChrBslash;
      3'd1:    chr = u2e_pkg::ChrLowU;
      default: chr = u2e_pkg::hex_char(nib);
    endcase
    if (job_i.kind == u2e_pkg::JOB_CHAR) begin
      chr = job_i.hi[6:0];
    end
  end

  // Load the output register whenever it is free or being taken
  assign advance   = !out_valid_q || pop_i;
  assign job_pop_o = advance && job_valid_i && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = job_valid_i;
      if (job_valid_i) begin
        idx_d = is_last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the character until it is taken
  always_ff @(posedge clk_i) begin
    if (advance && job_valid_i) begin
      out_char_q <= chr;
      last_q     <= is_last;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_char_o = out_char_q;
  assign last_o     = last_q;

endmodule

// ===== design/utf8_to_unicode_escape.sv =====
// UTF-8 to \uXXXX escape converter: takes one byte per cycle while full is low and gives
// one character per cycle while it is popped; requests pass through the queue and each
// character is registered. The back end spells 1, 6 or 12 characters per request.
// The request queue of QUEUE_DEPTH entries lets bytes in while an escape is spelled out.
// Reset (rst_ni low, asynchronous) empties queue and output, clears the sequence state.
// Depends on u2e_pkg, u2e_front, u2e_fifo and u2e_back.
`timescale 1ns / 1ps

module utf8_to_unicode_escape #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       restart_i,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char_o,
  output logic       last_of_run_o
);

  logic          accept;
  logic          job_valid;
  u2e_pkg::job_t job_in, job_head;
  logic          fifo_empty, job_pop;

  assign accept = push && !full;

  // Decode bytes into requests
  u2e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .restart_i   (restart_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  // Queue requests between front and back
  u2e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_valid),
    .wr_data_i (job_in),
    .rd_i      (job_pop),
    .rd_data_o (job_head),
    .full_o    (full),
    .empty_o   (fifo_empty)
  );

  // Spell requests out as characters
  u2e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!fifo_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_char_o  (out_char_o),
    .last_o      (last_of_run_o)
  );

endmodule

// ===== design/u2e_checker.sv =====
// Port-level checks of the escape converter, bound to the top level.
// Depends on assert_macros.svh, u2e_pkg and utf8_to_unicode_escape.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u2e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [6:0] out_char_o,
  input logic       last_of_run_o
);

  logic       prev_bs_q;
  logic       shown, stall, is_u, is_digit, is_hex_uc, inner_ok;
  logic [7:0] res_word;

  assign shown     = !empty;
  assign stall     = !empty && !pop;
  assign res_word  = {last_of_run_o, out_char_o};
  assign is_u      = (out_char_o == u2e_pkg::ChrLowU);
  assign is_digit  = (out_char_o >= 7'h30) && (out_char_o <= 7'h39);
  assign is_hex_uc = (out_char_o >= 7'h41) && (out_char_o <= 7'h46);
  assign inner_ok  = is_digit || is_hex_uc || is_u || (out_char_o == u2e_pkg::ChrBslash);

  // Remember that the last character taken opened an escape
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_bs_q <= 1'b0;
    end else if (pop && !empty) begin
      prev_bs_q <= (out_char_o == u2e_pkg::ChrBslash) && !last_of_run_o;
    end
  end

  `ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |-> empty, "output not empty in reset")
  `ASSERT_PROP(a_hold_stall, clk_i, rst_ni, stall |=> shown && $stable(res_word), "result moved")
  `ASSERT_PROP(a_u_after_bs, clk_i, rst_ni, shown && prev_bs_q |-> is_u && !last_of_run_o, "no u")
  `ASSERT_PROP(a_inner_chars, clk_i, rst_ni, shown && !last_of_run_o |-> inner_ok, "bad char")

endmodule

bind utf8_to_unicode_escape u2e_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .out_char_o    (out_char_o),
  .last_of_run_o (last_of_run_o)
);
